>>> design/assert_macros.svh
// Assertion macros used by the tag store RTL.
// Needs clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked every cycle outside reset.
`define LPB_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tag store assertion failed");
// Checked also during reset.
`define LPB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tag store assertion failed");
`endif

>>> design/lpbts_pkg.sv
// Package for the LRU page buffer tag store: defaults, codes and the result type.
// No dependencies.
`timescale 1ns / 1ps
package lpbts_pkg;
  localparam int SLOTS_DEF     = 16;
  localparam int PAGE_BITS_DEF = 32;
  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [2:0] CMD_FIND   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADSLOT  = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] result_slot;
    logic       writeback_needed;
    logic [7:0] writeback_table;
    logic [3:0] lru_slot;
    logic [4:0] occupancy;
  } res_t;
endpackage

>>> design/lpbts_ifs.sv
// Request and response channel interfaces of the tag store.
// Depends on nothing; page width is a parameter.
`timescale 1ns / 1ps
interface lpbts_req_if #(parameter int PAGE_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [2:0]           command;
  logic [7:0]           table_number;
  logic [PAGE_BITS-1:0] page_number;
  logic [3:0]           slot_handle;
  modport source (output valid, command, table_number, page_number, slot_handle,
                  input ready);
  modport sink (input valid, command, table_number, page_number, slot_handle,
                output ready);
endinterface

interface lpbts_rsp_if #(parameter int PAGE_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [3:0]           result_slot;
  logic                 writeback_needed;
  logic [7:0]           writeback_table;
  logic [PAGE_BITS-1:0] writeback_page;
  logic [3:0]           lru_slot;
  logic [4:0]           occupancy;
  modport source (output valid, status, result_slot, writeback_needed, writeback_table,
                  writeback_page, lru_slot, occupancy, input ready);
  modport sink (input valid, status, result_slot, writeback_needed, writeback_table,
                writeback_page, lru_slot, occupancy, output ready);
endinterface

>>> design/lru_page_buffer_tag_store.sv
// LRU page buffer tag store. Each command takes one pass over the tag RAM, one
// slot a cycle. Find, insert and failed commands go straight to the pass;
// delete and touches first read their slot. After the pass the result is
// registered into the output register. A result still held in the output
// register stalls the sequencer. The next command is taken once the result sits
// in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_page_buffer_tag_store import lpbts_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lpbts_req_if.sink  req,
  lpbts_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);
  localparam int SB = $clog2(SLOTS);
  localparam int W  = 1 + SB + 8 + PAGE_BITS;

  logic [4:0]           cap;
  logic                 ram_we;
  logic [SB-1:0]        ram_waddr;
  logic [W-1:0]         ram_wdata;
  logic [SB-1:0]        ram_raddr;
  logic [W-1:0]         ram_rdata;
  logic                 res_valid;
  res_t                 res;
  logic [PAGE_BITS-1:0] res_page;
  logic                 res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  lpbts_ctrl #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_ctrl (
    .clk, .rst, .req, .cap,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata,
    .res_valid, .res, .res_page, .res_take
  );

  lpbts_ram #(.WIDTH(W), .DEPTH(SLOTS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign res_take = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.status           <= res.status;
      rsp.result_slot      <= res.result_slot;
      rsp.writeback_needed <= res.writeback_needed;
      rsp.writeback_table  <= res.writeback_table;
      rsp.writeback_page   <= res_page;
      rsp.lru_slot         <= res.lru_slot;
      rsp.occupancy        <= res.occupancy;
    end
  end

  `LPB_ASSERT(a_occ_bound, rsp.valid |-> (32'(rsp.occupancy) <= SLOTS))
  `LPB_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready)
  `LPB_ASSERT(a_wb_only_ok, (rsp.valid && rsp.writeback_needed) |-> (rsp.status == ST_OK))
  `LPB_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp.valid)
endmodule

>>> design/lpbts_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lpbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/lpbts_ctrl.sv
// Command sequencer: pre-read of the addressed slot for delete and touches, then one pass over the
// tag RAM that matches keys, moves ranks and finds the LRU slot.
// Depends on lpbts_pkg and lpbts_req_if.
`timescale 1ns / 1ps
module lpbts_ctrl import lpbts_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int SB = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1),
  localparam int W  = 1 + SB + 8 + PAGE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  lpbts_req_if.sink            req,
  input  logic [4:0]           cap,
  output logic                 ram_we,
  output logic [SB-1:0]        ram_waddr,
  output logic [W-1:0]         ram_wdata,
  output logic [SB-1:0]        ram_raddr,
  input  logic [W-1:0]         ram_rdata,
  output logic                 res_valid,
  output res_t                 res,
  output logic [PAGE_BITS-1:0] res_page,
  input  logic                 res_take
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_PRW  = 6'b000100,
    S_SCAN = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  localparam logic [SB:0] SLOTS_C = (SB + 1)'(SLOTS);
  localparam logic [SB-1:0] LAST = SB'(SLOTS - 1);

  state_t               state;
  logic [2:0]           cmd;
  logic                 act;
  logic [7:0]           key_tbl;
  logic [PAGE_BITS-1:0] key_pg;
  logic [SB-1:0]        h;
  logic [1:0]           status;
  logic [SB-1:0]        rslot;
  logic                 hit;
  logic                 got;
  logic [SB-1:0]        best;
  logic [SB-1:0]        r;
  logic                 wb;
  logic [7:0]           wbt;
  logic [PAGE_BITS-1:0] wbp;
  logic [CW-1:0]        occ;
  logic [CW-1:0]        occ_new;
  logic [SB-1:0]        lru;
  logic [SB:0]          rcnt;
  logic                 pv;
  logic [SB-1:0]        pidx;
  logic [SLOTS-1:0]     valid;

  logic [SB-1:0]        h_idx;
  logic                 h_ok;
  logic                 ins_ok;
  logic                 rd_dirty;
  logic [SB-1:0]        rd_rank;
  logic [7:0]           rd_tbl;
  logic [PAGE_BITS-1:0] rd_pg;
  logic                 e_v;
  logic                 e_keep;
  logic [SB-1:0]        new_rank;
  logic                 new_dirty;
  logic                 p_we;

  assign h_idx  = SB'(req.slot_handle);
  assign h_ok   = (32'(req.slot_handle) < SLOTS) && valid[h_idx];
  assign ins_ok = (32'(occ) < 32'(cap)) && (32'(occ) < SLOTS);
  assign req.ready = (state == S_IDLE);

  assign rd_pg    = ram_rdata[PAGE_BITS-1:0];
  assign rd_tbl   = ram_rdata[PAGE_BITS +: 8];
  assign rd_rank  = ram_rdata[PAGE_BITS+8 +: SB];
  assign rd_dirty = ram_rdata[W-1];
  assign e_v      = valid[pidx];

  always_comb begin
    new_rank  = rd_rank;
    new_dirty = rd_dirty;
    p_we      = 1'b0;
    e_keep    = e_v;
    if (act) begin
      case (cmd)
        CMD_INSERT: begin
          if (e_v) begin
            new_rank = rd_rank + 1'b1;
            p_we     = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (pidx == h) begin
            e_keep = 1'b0;
          end else if (e_v && rd_rank > r) begin
            new_rank = rd_rank - 1'b1;
            p_we     = 1'b1;
          end
        end
        CMD_READ, CMD_WRITE: begin
          if (pidx == h) begin
            new_rank  = '0;
            new_dirty = rd_dirty | (cmd == CMD_WRITE);
            p_we      = 1'b1;
          end else if (e_v && rd_rank < r) begin
            new_rank = rd_rank + 1'b1;
            p_we     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ram_raddr = (state == S_PRE) ? h : rcnt[SB-1:0];
    if (state == S_FIN) begin
      ram_we    = act && (cmd == CMD_INSERT);
      ram_waddr = rslot;
      ram_wdata = {1'b0, SB'(0), key_tbl, key_pg};
    end else begin
      ram_we    = (state == S_SCAN) && pv && p_we;
      ram_waddr = pidx;
      ram_wdata = {new_dirty, new_rank, rd_tbl, rd_pg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      occ   <= '0;
      pv    <= 1'b0;
      rcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd     <= req.command;
            key_tbl <= req.table_number;
            key_pg  <= req.page_number;
            h       <= h_idx;
            hit     <= 1'b0;
            got     <= 1'b0;
            best    <= '0;
            rslot   <= '0;
            lru     <= '0;
            wb      <= 1'b0;
            wbt     <= '0;
            wbp     <= '0;
            rcnt    <= '0;
            pv      <= 1'b0;
            occ_new <= occ;
            status  <= ST_OK;
            act     <= 1'b0;
            state   <= S_SCAN;
            case (req.command)
              CMD_FIND: act <= 1'b1;
              CMD_INSERT: begin
                if (ins_ok) begin
                  act     <= 1'b1;
                  occ_new <= CW'(occ + 1'b1);
                end else begin
                  status <= ST_FULL;
                end
              end
              CMD_DELETE, CMD_READ, CMD_WRITE: begin
                if (h_ok) begin
                  act   <= 1'b1;
                  state <= S_PRE;
                  if (req.command == CMD_DELETE) begin
                    occ_new <= CW'(occ - 1'b1);
                  end
                end else begin
                  status <= ST_BADSLOT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PRE: state <= S_PRW;
        S_PRW: begin
          r <= rd_rank;
          if (cmd == CMD_DELETE && rd_dirty) begin
            wb  <= 1'b1;
            wbt <= rd_tbl;
            wbp <= rd_pg;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rcnt != SLOTS_C) begin
            rcnt <= rcnt + 1'b1;
            pidx <= rcnt[SB-1:0];
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (act && cmd == CMD_FIND && e_v && rd_tbl == key_tbl && rd_pg == key_pg
                && (!hit || rd_rank < best)) begin
              hit   <= 1'b1;
              best  <= rd_rank;
              rslot <= pidx;
            end
            if (act && cmd == CMD_INSERT && !e_v && !got) begin
              got   <= 1'b1;
              rslot <= pidx;
            end
            if (act && cmd == CMD_DELETE && pidx == h) begin
              valid[pidx] <= 1'b0;
            end
            if (e_keep && occ_new != '0 && CW'(new_rank) == CW'(occ_new - 1'b1)) begin
              lru <= pidx;
            end
            if (pidx == LAST) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          occ <= occ_new;
          if (act && cmd == CMD_FIND && !hit) begin
            status <= ST_NOTFOUND;
          end
          if (act && cmd == CMD_INSERT) begin
            valid[rslot] <= 1'b1;
            if (occ_new == CW'(1)) begin
              lru <= rslot;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_valid = (state == S_DONE);
  assign res_page  = wbp;
  always_comb begin
    res.status           = status;
    res.result_slot      = 4'(rslot);
    res.writeback_needed = wb;
    res.writeback_table  = wbt;
    res.lru_slot         = 4'(lru);
    res.occupancy        = 5'(occ);
  end
endmodule
